// File: rtl/ccf_pkg.sv
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared types and codes for the client connect handshake controller.
// ----------------------------------------------------------------------------
package ccf_pkg;

  localparam int TIMER_BITS = 16;
  localparam int PERIOD_W   = 16;
  localparam int RETRY_W    = 3;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [PERIOD_W-1:0] TIMEOUT_RST = PERIOD_W'(6);
  localparam logic [RETRY_W-1:0]  RETRY_RST   = RETRY_W'(5);
  localparam logic [PERIOD_W-1:0] HOLD_RST    = PERIOD_W'(10);

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_RETRY   = 2'd1,
    REG_HOLD    = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LINK      = 3'd1,
    PH_START     = 3'd2,
    PH_RESULT    = 3'd3,
    PH_SETUPWAIT = 3'd4,
    PH_SETUP     = 3'd5,
    PH_SYNC      = 3'd6,
    PH_FAIL      = 3'd7
  } phase_t;

  localparam logic [3:0] K_POLL    = 4'd0;
  localparam logic [3:0] K_BEGIN   = 4'd1;
  localparam logic [3:0] K_LINKACK = 4'd2;
  localparam logic [3:0] K_QUEUE   = 4'd3;
  localparam logic [3:0] K_START   = 4'd4;
  localparam logic [3:0] K_FULL    = 4'd5;
  localparam logic [3:0] K_RESULT  = 4'd6;
  localparam logic [3:0] K_SETUP   = 4'd7;
  localparam logic [3:0] K_SYNCED  = 4'd8;
  localparam logic [3:0] K_BROKEN  = 4'd9;

  localparam logic [2:0] S_NONE     = 3'd0;
  localparam logic [2:0] S_CONNECT  = 3'd1;
  localparam logic [2:0] S_SETTINGS = 3'd2;
  localparam logic [2:0] S_PING     = 3'd3;
  localparam logic [2:0] S_ACK      = 3'd4;

  localparam logic [3:0] N_NONE         = 4'd0;
  localparam logic [3:0] N_BEGUN        = 4'd1;
  localparam logic [3:0] N_LINKED       = 4'd2;
  localparam logic [3:0] N_LINK_REFUSED = 4'd3;
  localparam logic [3:0] N_RETRY        = 4'd4;
  localparam logic [3:0] N_LINK_TIMEOUT = 4'd5;
  localparam logic [3:0] N_QUEUE        = 4'd6;
  localparam logic [3:0] N_CONNECTING   = 4'd7;
  localparam logic [3:0] N_FULL         = 4'd8;
  localparam logic [3:0] N_REFUSED      = 4'd9;
  localparam logic [3:0] N_TIMEOUT      = 4'd10;
  localparam logic [3:0] N_LOAD_FAIL    = 4'd11;
  localparam logic [3:0] N_SYNCED       = 4'd12;
  localparam logic [3:0] N_BROKEN       = 4'd13;

  localparam logic [1:0] L_MAP_MISSING  = 2'd1;
  localparam logic [1:0] L_TILE_MISSING = 2'd2;

  typedef struct packed {
    logic [3:0] kind;
    logic       tick;
    logic [2:0] ack_code;
    logic [1:0] load_result;
    logic       setup_done;
  } in_item_t;

  typedef struct packed {
    logic [2:0] conn_state;
    logic [2:0] send_action;
    logic [3:0] notice;
    logic [2:0] reason;
    logic       load_error;
  } out_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] timeout_ticks;
    logic [RETRY_W-1:0]  retry_limit;
    logic [PERIOD_W-1:0] failure_hold_ticks;
  } cfg_t;

endpackage

// File: rtl/ccf_cfg_regs.sv
// ----------------------------------------------------------------------------
// ccf_cfg_regs
// APB register file: timeout, retry limit and failure hold period.
// ----------------------------------------------------------------------------
module ccf_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ccf_pkg::ADDR_W-1:0] paddr,
  input  logic [ccf_pkg::DATA_W-1:0] pwdata,
  output logic [ccf_pkg::DATA_W-1:0] prdata,
  output ccf_pkg::cfg_t             cfg
);

  ccf_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[3:2];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks      <= ccf_pkg::TIMEOUT_RST;
      cfg_r.retry_limit        <= ccf_pkg::RETRY_RST;
      cfg_r.failure_hold_ticks <= ccf_pkg::HOLD_RST;
    end else if (wr_en) begin
      unique case (idx)
        ccf_pkg::REG_TIMEOUT: cfg_r.timeout_ticks      <= pwdata[ccf_pkg::PERIOD_W-1:0];
        ccf_pkg::REG_RETRY:   cfg_r.retry_limit        <= pwdata[ccf_pkg::RETRY_W-1:0];
        ccf_pkg::REG_HOLD:    cfg_r.failure_hold_ticks <= pwdata[ccf_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ccf_pkg::REG_TIMEOUT: prdata = ccf_pkg::DATA_W'(cfg_r.timeout_ticks);
      ccf_pkg::REG_RETRY:   prdata = ccf_pkg::DATA_W'(cfg_r.retry_limit);
      ccf_pkg::REG_HOLD:    prdata = ccf_pkg::DATA_W'(cfg_r.failure_hold_ticks);
      default:              prdata = '0;
    endcase
  end

endmodule

// File: rtl/ccf_core.sv
// ----------------------------------------------------------------------------
// ccf_core
// Connection state, retry count and tick timers; computes one result per item.
// ----------------------------------------------------------------------------
module ccf_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  ccf_pkg::in_item_t  item,
  input  ccf_pkg::cfg_t      cfg,
  output ccf_pkg::out_item_t res
);

  typedef logic [ccf_pkg::TIMER_BITS-1:0] cnt_t;

  ccf_pkg::phase_t             phase_r, phase_nxt;
  logic [ccf_pkg::RETRY_W-1:0] retry_r, retry_nxt;
  cnt_t                        ans_r, ans_nxt;
  cnt_t                        fail_r, fail_nxt;

  cnt_t ans_t, fail_t;
  logic ans_hit, fail_hit, result_phase, can_retry;
  logic [2:0] send;
  logic [3:0] notice;
  logic [2:0] reason;
  logic       lerr;

  assign ans_t  = (item.tick && ans_r  != '1) ? ans_r  + 1'b1 : ans_r;
  assign fail_t = (item.tick && fail_r != '1) ? fail_r + 1'b1 : fail_r;
  assign ans_hit  = 32'(ans_t)  >= 32'(cfg.timeout_ticks);
  assign fail_hit = 32'(fail_t) >= 32'(cfg.failure_hold_ticks);
  assign can_retry = retry_r < cfg.retry_limit;

  always_comb begin
    phase_nxt    = phase_r;
    retry_nxt    = retry_r;
    ans_nxt      = ans_t;
    fail_nxt     = fail_t;
    send         = ccf_pkg::S_NONE;
    notice       = ccf_pkg::N_NONE;
    reason       = '0;
    lerr         = 1'b0;
    result_phase = 1'b0;
    if (item.kind == ccf_pkg::K_BEGIN) begin
      ans_nxt   = '0;
      fail_nxt  = '0;
      retry_nxt = '0;
      phase_nxt = ccf_pkg::PH_LINK;
      notice    = ccf_pkg::N_BEGUN;
    end else if (item.kind == ccf_pkg::K_SYNCED) begin
      phase_nxt = ccf_pkg::PH_IDLE;
      notice    = ccf_pkg::N_SYNCED;
    end else if (item.kind == ccf_pkg::K_BROKEN) begin
      fail_nxt  = '0;
      phase_nxt = ccf_pkg::PH_FAIL;
      notice    = ccf_pkg::N_BROKEN;
    end else begin
      unique case (phase_r)
        ccf_pkg::PH_LINK: begin
          if (item.kind == ccf_pkg::K_LINKACK) begin
            ans_nxt   = '0;
            retry_nxt = '0;
            if (item.ack_code == '0) begin
              phase_nxt = ccf_pkg::PH_START;
              notice    = ccf_pkg::N_LINKED;
            end else begin
              phase_nxt = ccf_pkg::PH_FAIL;
              fail_nxt  = '0;
              notice    = ccf_pkg::N_LINK_REFUSED;
              reason    = item.ack_code;
            end
          end else if (ans_hit) begin
            ans_nxt = '0;
            if (can_retry) begin
              retry_nxt = retry_r + 1'b1;
              notice    = ccf_pkg::N_RETRY;
            end else begin
              phase_nxt = ccf_pkg::PH_FAIL;
              fail_nxt  = '0;
              notice    = ccf_pkg::N_LINK_TIMEOUT;
            end
          end
        end
        ccf_pkg::PH_START: begin
          if (item.kind == ccf_pkg::K_QUEUE) begin
            notice = ccf_pkg::N_QUEUE;
          end else if (item.kind == ccf_pkg::K_START) begin
            send         = ccf_pkg::S_CONNECT;
            notice       = ccf_pkg::N_CONNECTING;
            phase_nxt    = ccf_pkg::PH_RESULT;
            result_phase = 1'b1;
          end else if (item.kind == ccf_pkg::K_FULL) begin
            fail_nxt  = '0;
            phase_nxt = ccf_pkg::PH_FAIL;
            notice    = ccf_pkg::N_FULL;
          end
        end
        ccf_pkg::PH_RESULT: result_phase = 1'b1;
        ccf_pkg::PH_SETUPWAIT: begin
          if (item.kind == ccf_pkg::K_SETUP) begin
            if (item.load_result == ccf_pkg::L_MAP_MISSING ||
                item.load_result == ccf_pkg::L_TILE_MISSING) begin
              phase_nxt = ccf_pkg::PH_FAIL;
              fail_nxt  = '0;
              notice    = ccf_pkg::N_LOAD_FAIL;
              reason    = 3'(item.load_result);
            end else begin
              send      = ccf_pkg::S_PING;
              phase_nxt = ccf_pkg::PH_SETUP;
            end
          end
        end
        ccf_pkg::PH_SETUP: begin
          if (item.setup_done) begin
            send      = ccf_pkg::S_ACK;
            phase_nxt = ccf_pkg::PH_SYNC;
          end else begin
            send = ccf_pkg::S_PING;
          end
        end
        ccf_pkg::PH_FAIL: begin
          if (fail_hit) begin
            fail_nxt  = '0;
            lerr      = 1'b1;
            phase_nxt = ccf_pkg::PH_IDLE;
          end
        end
        default: ;
      endcase

      if (result_phase) begin
        if (item.kind == ccf_pkg::K_RESULT) begin
          if (item.ack_code != '0) begin
            phase_nxt = ccf_pkg::PH_FAIL;
            fail_nxt  = '0;
            notice    = ccf_pkg::N_REFUSED;
            reason    = item.ack_code;
          end else begin
            send      = ccf_pkg::S_SETTINGS;
            phase_nxt = ccf_pkg::PH_SETUPWAIT;
          end
        end else if (ans_hit) begin
          ans_nxt = '0;
          if (can_retry) begin
            retry_nxt = retry_r + 1'b1;
            send      = ccf_pkg::S_CONNECT;
          end else begin
            phase_nxt = ccf_pkg::PH_FAIL;
            fail_nxt  = '0;
            notice    = ccf_pkg::N_TIMEOUT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ccf_pkg::PH_IDLE;
      retry_r <= '0;
      ans_r   <= '0;
      fail_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      retry_r <= retry_nxt;
      ans_r   <= ans_nxt;
      fail_r  <= fail_nxt;
    end
  end

  assign res.conn_state  = phase_nxt;
  assign res.send_action = send;
  assign res.notice      = notice;
  assign res.reason      = reason;
  assign res.load_error  = lerr;

endmodule

// File: rtl/client_connect_handshake_fsm_top.sv
// ----------------------------------------------------------------------------
// client_connect_handshake_fsm_top
// Client join handshake controller with input and result registers.
// ----------------------------------------------------------------------------
//  channel | ports                          | role
//  in      | in_valid/in_ready/in_data      | message item (kind, tick, codes)
//  out     | out_valid/out_ready/out_data   | one result item per input item
//  cfg     | cfg_psel..cfg_pready           | APB timeout/retry/hold registers
//
//  Result registered from the input register through the state update; one item per cycle
//  sustained while out_ready holds, set by the single state update between the two registers.
//  Reset: phase idle, counts and retries zero, registers at defaults.
//  A stalled result holds the pipe; in_ready drops only when both stages full.
// ----------------------------------------------------------------------------
module client_connect_handshake_fsm_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ccf_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ccf_pkg::out_item_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ccf_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [ccf_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [ccf_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  ccf_pkg::cfg_t      cfg;
  ccf_pkg::in_item_t  in_r;
  ccf_pkg::out_item_t out_r, res;
  logic               in_vld_r, out_vld_r;
  logic               advance;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign cfg_pready = 1'b1;

  ccf_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  ccf_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (advance) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_r <= in_data;
    if (advance) out_r <= res;
  end

endmodule

// File: tb/client_connect_handshake_fsm_top_tb.sv
// ----------------------------------------------------------------------------
// client_connect_handshake_fsm_top_tb
// Self-checking bench for the client join handshake controller. Message items
// go in through a valid/ready channel with random gaps. A cycle-free model of
// the connection FSM, its retry count and its two tick timers predicts one
// result per item. Results are drained under random back-pressure and checked
// field by field, in order. Registers are set over APB between runs and read
// back. The directed walks cover retries, every failure path, the start
// fall-through and the load-error return to idle. Random sessions under
// several register settings, the extremes among them, follow.
// ----------------------------------------------------------------------------
module client_connect_handshake_fsm_top_tb;

  localparam logic [3:0] KIND_OTHER = 4'd10;
  localparam logic [3:0] KIND_TOP   = 4'd15;
  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [1:0] L_OK       = 2'd0;
  localparam logic [1:0] L_SPARE    = 2'd3;
  localparam int unsigned REPORT_CAP = 200;
  localparam int IN_W = $bits(ccf_pkg::in_item_t);

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  ccf_pkg::in_item_t          in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  ccf_pkg::out_item_t         out_data;
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [ccf_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [ccf_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [ccf_pkg::DATA_W-1:0] cfg_prdata;
  logic                       cfg_pready;

  client_connect_handshake_fsm_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state and register copy
  logic [ccf_pkg::PERIOD_W-1:0]   cfg_timeout = ccf_pkg::TIMEOUT_RST;
  logic [ccf_pkg::RETRY_W-1:0]    cfg_retries = ccf_pkg::RETRY_RST;
  logic [ccf_pkg::PERIOD_W-1:0]   cfg_hold    = ccf_pkg::HOLD_RST;
  ccf_pkg::phase_t                fsm_phase   = ccf_pkg::PH_IDLE;
  logic [ccf_pkg::RETRY_W-1:0]    retry_cnt   = '0;
  logic [ccf_pkg::TIMER_BITS-1:0] answer_ticks = '0;
  logic [ccf_pkg::TIMER_BITS-1:0] hold_ticks   = '0;

  ccf_pkg::out_item_t expected_results[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned sync_count = 0;
  int unsigned hold_expiries = 0;
  int unsigned in_burst = 0;

  function automatic bit timer_due(inout logic [ccf_pkg::TIMER_BITS-1:0] cnt,
                                   input logic [ccf_pkg::PERIOD_W-1:0] period);
    if (cnt >= period) begin
      cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void enter_failure();
    fsm_phase  = ccf_pkg::PH_FAIL;
    hold_ticks = '0;
  endfunction

  function automatic ccf_pkg::out_item_t step_handshake(input ccf_pkg::in_item_t m);
    ccf_pkg::out_item_t r;
    logic [3:0]         k;
    logic               in_result;
    r = '0;
    in_result = 1'b0;
    k = (m.kind > KIND_OTHER) ? KIND_OTHER : m.kind;
    if (m.tick) begin
      if (answer_ticks != '1) answer_ticks = answer_ticks + 1'b1;
      if (hold_ticks != '1) hold_ticks = hold_ticks + 1'b1;
    end
    if (k == ccf_pkg::K_BEGIN) begin
      answer_ticks = '0;
      hold_ticks = '0;
      retry_cnt = '0;
      fsm_phase = ccf_pkg::PH_LINK;
      r.notice = ccf_pkg::N_BEGUN;
    end else if (k == ccf_pkg::K_SYNCED) begin
      fsm_phase = ccf_pkg::PH_IDLE;
      r.notice = ccf_pkg::N_SYNCED;
    end else if (k == ccf_pkg::K_BROKEN) begin
      enter_failure();
      r.notice = ccf_pkg::N_BROKEN;
    end else begin
      case (fsm_phase)
        ccf_pkg::PH_LINK: begin
          if (k == ccf_pkg::K_LINKACK) begin
            answer_ticks = '0;
            retry_cnt = '0;
            if (m.ack_code == RC_OK) begin
              fsm_phase = ccf_pkg::PH_START;
              r.notice = ccf_pkg::N_LINKED;
            end else begin
              enter_failure();
              r.notice = ccf_pkg::N_LINK_REFUSED;
              r.reason = m.ack_code;
            end
          end else if (timer_due(answer_ticks, cfg_timeout)) begin
            if (retry_cnt < cfg_retries) begin
              retry_cnt = retry_cnt + 1'b1;
              r.notice = ccf_pkg::N_RETRY;
            end else begin
              enter_failure();
              r.notice = ccf_pkg::N_LINK_TIMEOUT;
            end
          end
        end
        ccf_pkg::PH_START: begin
          if (k == ccf_pkg::K_QUEUE) begin
            r.notice = ccf_pkg::N_QUEUE;
          end else if (k == ccf_pkg::K_START) begin
            r.send_action = ccf_pkg::S_CONNECT;
            r.notice = ccf_pkg::N_CONNECTING;
            fsm_phase = ccf_pkg::PH_RESULT;
            in_result = 1'b1;
          end else if (k == ccf_pkg::K_FULL) begin
            enter_failure();
            r.notice = ccf_pkg::N_FULL;
          end
        end
        ccf_pkg::PH_RESULT: in_result = 1'b1;
        ccf_pkg::PH_SETUPWAIT: begin
          if (k == ccf_pkg::K_SETUP) begin
            if (m.load_result == ccf_pkg::L_MAP_MISSING ||
                m.load_result == ccf_pkg::L_TILE_MISSING) begin
              enter_failure();
              r.notice = ccf_pkg::N_LOAD_FAIL;
              r.reason = {1'b0, m.load_result};
            end else begin
              r.send_action = ccf_pkg::S_PING;
              fsm_phase = ccf_pkg::PH_SETUP;
            end
          end
        end
        ccf_pkg::PH_SETUP: begin
          if (m.setup_done) begin
            r.send_action = ccf_pkg::S_ACK;
            fsm_phase = ccf_pkg::PH_SYNC;
            sync_count++;
          end else begin
            r.send_action = ccf_pkg::S_PING;
          end
        end
        ccf_pkg::PH_FAIL: begin
          if (timer_due(hold_ticks, cfg_hold)) begin
            r.load_error = 1'b1;
            fsm_phase = ccf_pkg::PH_IDLE;
            hold_expiries++;
          end
        end
        default: ;
      endcase
      if (in_result) begin
        if (k == ccf_pkg::K_RESULT) begin
          if (m.ack_code != RC_OK) begin
            enter_failure();
            r.notice = ccf_pkg::N_REFUSED;
            r.reason = m.ack_code;
          end else begin
            r.send_action = ccf_pkg::S_SETTINGS;
            fsm_phase = ccf_pkg::PH_SETUPWAIT;
          end
        end else if (timer_due(answer_ticks, cfg_timeout)) begin
          if (retry_cnt < cfg_retries) begin
            retry_cnt = retry_cnt + 1'b1;
            r.send_action = ccf_pkg::S_CONNECT;
          end else begin
            enter_failure();
            r.notice = ccf_pkg::N_TIMEOUT;
          end
        end
      end
    end
    r.conn_state = fsm_phase;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    errors++;
    if (errors <= REPORT_CAP)
      $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    ccf_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result item", 32'd0, 32'(out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.conn_state !== want.conn_state)
          flag_mismatch("conn_state", 32'(want.conn_state), 32'(out_data.conn_state));
        if (out_data.send_action !== want.send_action)
          flag_mismatch("send_action", 32'(want.send_action),
                        32'(out_data.send_action));
        if (out_data.notice !== want.notice)
          flag_mismatch("notice", 32'(want.notice), 32'(out_data.notice));
        if (out_data.reason !== want.reason)
          flag_mismatch("reason", 32'(want.reason), 32'(out_data.reason));
        if (out_data.load_error !== want.load_error)
          flag_mismatch("load_error", 32'(want.load_error), 32'(out_data.load_error));
      end
    end
  end

  // result-side back-pressure
  initial begin : out_stall_gen
    int unsigned n;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  task automatic send_msg(input ccf_pkg::in_item_t m);
    int unsigned gap;
    if (in_burst > 0) begin
      in_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) in_burst = $urandom_range(20, 60);
      gap = idle_len();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(step_handshake(m));
    items_sent++;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input ccf_pkg::reg_idx_t idx,
                            input logic [ccf_pkg::DATA_W-1:0] wdata,
                            output logic [ccf_pkg::DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_registers();
    logic [ccf_pkg::DATA_W-1:0] rd;
    cfg_access(1'b0, ccf_pkg::REG_TIMEOUT, '0, rd);
    if (rd[ccf_pkg::PERIOD_W-1:0] !== cfg_timeout)
      flag_mismatch("timeout_ticks", 32'(cfg_timeout), 32'(rd[ccf_pkg::PERIOD_W-1:0]));
    cfg_access(1'b0, ccf_pkg::REG_RETRY, '0, rd);
    if (rd[ccf_pkg::RETRY_W-1:0] !== cfg_retries)
      flag_mismatch("retry_limit", 32'(cfg_retries), 32'(rd[ccf_pkg::RETRY_W-1:0]));
    cfg_access(1'b0, ccf_pkg::REG_HOLD, '0, rd);
    if (rd[ccf_pkg::PERIOD_W-1:0] !== cfg_hold)
      flag_mismatch("failure_hold_ticks", 32'(cfg_hold),
                    32'(rd[ccf_pkg::PERIOD_W-1:0]));
  endtask

  task automatic apply_settings(input logic [ccf_pkg::PERIOD_W-1:0] timeout,
                                input logic [ccf_pkg::RETRY_W-1:0] retries,
                                input logic [ccf_pkg::PERIOD_W-1:0] hold);
    logic [ccf_pkg::DATA_W-1:0] rd;
    drain_pipe();
    cfg_access(1'b1, ccf_pkg::REG_TIMEOUT, ccf_pkg::DATA_W'(timeout), rd);
    cfg_access(1'b1, ccf_pkg::REG_RETRY, ccf_pkg::DATA_W'(retries), rd);
    cfg_access(1'b1, ccf_pkg::REG_HOLD, ccf_pkg::DATA_W'(hold), rd);
    cfg_timeout = timeout;
    cfg_retries = retries;
    cfg_hold    = hold;
    verify_registers();
    settings_used++;
  endtask

  function automatic ccf_pkg::in_item_t msg(input logic [3:0] k, input logic t = 1'b0,
                                            input logic [2:0] rc = RC_OK,
                                            input logic [1:0] ld = L_OK,
                                            input logic d = 1'b0);
    ccf_pkg::in_item_t m;
    m.kind = k;
    m.tick = t;
    m.ack_code = rc;
    m.load_result = ld;
    m.setup_done = d;
    return m;
  endfunction

  // mostly well-formed session traffic, steered by the model's current phase
  function automatic ccf_pkg::in_item_t pick_msg();
    ccf_pkg::in_item_t m;
    int unsigned       p;
    m.kind = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(10, 15)) : ccf_pkg::K_POLL;
    m.tick = ($urandom_range(0, 9) < 6);
    m.ack_code = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : RC_OK;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: m.load_result = L_OK;
      5:             m.load_result = L_SPARE;
      6, 7:          m.load_result = ccf_pkg::L_MAP_MISSING;
      default:       m.load_result = ccf_pkg::L_TILE_MISSING;
    endcase
    m.setup_done = ($urandom_range(0, 3) == 0);
    p = $urandom_range(0, 99);
    if (p < 5) begin
      m = IN_W'($urandom);
    end else if (p < 8) begin
      m.kind = ccf_pkg::K_BEGIN;
    end else if (p < 10) begin
      m.kind = ccf_pkg::K_BROKEN;
    end else begin
      case (fsm_phase)
        ccf_pkg::PH_IDLE:      if (p < 75) m.kind = ccf_pkg::K_BEGIN;
        ccf_pkg::PH_LINK:      if (p < 35) m.kind = ccf_pkg::K_LINKACK;
        ccf_pkg::PH_START: begin
          if (p < 45) m.kind = ccf_pkg::K_START;
          else if (p < 60) m.kind = ccf_pkg::K_QUEUE;
          else if (p < 64) m.kind = ccf_pkg::K_FULL;
        end
        ccf_pkg::PH_RESULT:    if (p < 40) m.kind = ccf_pkg::K_RESULT;
        ccf_pkg::PH_SETUPWAIT: if (p < 50) m.kind = ccf_pkg::K_SETUP;
        ccf_pkg::PH_SYNC:      if (p < 55) m.kind = ccf_pkg::K_SYNCED;
        default: ;
      endcase
    end
    return m;
  endfunction

  task automatic test_register_access();
    verify_registers();
    apply_settings('1, '1, '1);
    apply_settings(ccf_pkg::PERIOD_W'(1), '0, ccf_pkg::PERIOD_W'(1));
  endtask

  // link retry and timeout, hold expiry, refusals, start merge, load failure
  task automatic test_directed_walk();
    apply_settings(ccf_pkg::PERIOD_W'(2), ccf_pkg::RETRY_W'(1), ccf_pkg::PERIOD_W'(2));
    send_msg(msg(ccf_pkg::K_POLL));
    send_msg(msg(ccf_pkg::K_BEGIN));
    send_msg(msg(ccf_pkg::K_POLL, 1'b1));
    send_msg(msg(ccf_pkg::K_POLL, 1'b1));
    send_msg(msg(KIND_TOP, 1'b1));
    send_msg(msg(KIND_OTHER, 1'b1));
    send_msg(msg(ccf_pkg::K_POLL, 1'b1));
    send_msg(msg(ccf_pkg::K_POLL, 1'b1));
    send_msg(msg(ccf_pkg::K_BEGIN));
    send_msg(msg(ccf_pkg::K_LINKACK, 1'b0, 3'($urandom_range(1, 7))));
    send_msg(msg(ccf_pkg::K_BEGIN));
    send_msg(msg(ccf_pkg::K_LINKACK));
    send_msg(msg(ccf_pkg::K_QUEUE));
    send_msg(msg(ccf_pkg::K_POLL, 1'b1));
    send_msg(msg(ccf_pkg::K_POLL, 1'b1));
    send_msg(msg(ccf_pkg::K_START));
    send_msg(msg(ccf_pkg::K_RESULT, 1'b0, 3'($urandom_range(1, 7))));
    send_msg(msg(ccf_pkg::K_BROKEN));
    send_msg(msg(ccf_pkg::K_BEGIN));
    send_msg(msg(ccf_pkg::K_LINKACK));
    send_msg(msg(ccf_pkg::K_START));
    send_msg(msg(ccf_pkg::K_RESULT));
    send_msg(msg(ccf_pkg::K_SETUP, 1'b0, RC_OK, ccf_pkg::L_MAP_MISSING));
    send_msg(msg(ccf_pkg::K_SYNCED));
  endtask

  // start timing out with no retries left, server full, full path to sync
  task automatic test_directed_edges();
    apply_settings(ccf_pkg::PERIOD_W'(1), '0, ccf_pkg::PERIOD_W'(1));
    send_msg(msg(ccf_pkg::K_BEGIN));
    send_msg(msg(ccf_pkg::K_LINKACK));
    send_msg(msg(ccf_pkg::K_POLL, 1'b1));
    send_msg(msg(ccf_pkg::K_START));
    send_msg(msg(ccf_pkg::K_BEGIN));
    send_msg(msg(ccf_pkg::K_LINKACK));
    send_msg(msg(ccf_pkg::K_FULL));
    send_msg(msg(ccf_pkg::K_BEGIN));
    send_msg(msg(ccf_pkg::K_LINKACK));
    send_msg(msg(ccf_pkg::K_START));
    send_msg(msg(ccf_pkg::K_RESULT));
    send_msg(msg(ccf_pkg::K_SETUP, 1'b0, RC_OK, L_SPARE));
    send_msg(msg(ccf_pkg::K_POLL, 1'b0, RC_OK, L_OK, 1'b0));
    send_msg(msg(ccf_pkg::K_POLL, 1'b0, RC_OK, L_OK, 1'b1));
    send_msg(msg(ccf_pkg::K_SYNCED));
  endtask

  task automatic test_random_sessions();
    for (int s = 0; s < 8; s++) begin
      case (s)
        0:       apply_settings(ccf_pkg::TIMEOUT_RST, ccf_pkg::RETRY_RST,
                                ccf_pkg::HOLD_RST);
        1:       apply_settings(ccf_pkg::PERIOD_W'(1), '0, ccf_pkg::PERIOD_W'(1));
        2:       apply_settings('1, '1, '1);
        default: apply_settings(ccf_pkg::PERIOD_W'($urandom_range(1, 8)),
                                ccf_pkg::RETRY_W'($urandom_range(0, 7)),
                                ccf_pkg::PERIOD_W'($urandom_range(1, 6)));
      endcase
      repeat (236) send_msg(pick_msg());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    test_directed_walk();
    test_directed_edges();
    test_random_sessions();
    drain_pipe();
    repeat (10) @(posedge clk);
    $display("Checked %0d items under %0d register settings", items_sent, settings_used);
    $display("%0d sessions reached sync, %0d failure holds ran out", sync_count,
             hold_expiries);
    if (errors == 0) begin
      $display("PASS client_connect_handshake_fsm_top");
    end else begin
      $display("FAIL client_connect_handshake_fsm_top");
    end
    $finish;
  end

  initial begin
    #14_400_000;
    $display("FAIL client_connect_handshake_fsm_top");
    $finish;
  end

endmodule
